[rtl/core/lrs_pkg.sv]
`timescale 1ns / 1ps
// lrs_pkg: shared widths, defaults, job and issue types of the 16 kHz resampler
// no dependencies

package lrs_pkg;

	// default configuration
	localparam int TARGET_RATE_DEF = 16000;
	localparam int MAX_OUT_DEF     = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 18;

	// what the back end does with one queued sample
	typedef enum logic [1:0] {
		JOB_PASS,
		JOB_FIRST_LAST,
		JOB_MID,
		JOB_LAST
	} job_kind_t;

	typedef struct packed {
		job_kind_t                   kind;
		logic                        last;
		logic signed [SAMPLE_W-1:0]  prev;
		logic signed [SAMPLE_W-1:0]  cur;
	} job_t;

	// one interpolation request from the sequencer to the datapath
	typedef struct packed {
		logic signed [SAMPLE_W-1:0]  a;
		logic signed [SAMPLE_W-1:0]  b;
		logic [RATE_W-1:0]           p;
		logic                        last;
	} issue_t;

	typedef enum logic {
		BK_RUN,
		BK_DIV
	} back_state_t;

endpackage

[rtl/core/lrs_in_if.sv]
`timescale 1ns / 1ps
// lrs_in_if: input pcm stream channel, valid/ready with sample and end-of-clip flag
// depends on lrs_pkg

interface lrs_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lrs_pkg::SAMPLE_W-1:0]  sample_in;
	logic                                 last_in;

	modport source (output valid, output sample_in, output last_in, input ready);
	modport sink (input valid, input sample_in, input last_in, output ready);
endinterface

[rtl/core/lrs_out_if.sv]
`timescale 1ns / 1ps
// lrs_out_if: resampled 16 kHz stream channel, valid/ready with sample and end flag
// depends on lrs_pkg

interface lrs_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lrs_pkg::SAMPLE_W-1:0]  sample_out;
	logic                                 last_out;

	modport source (output valid, output sample_out, output last_out, input ready);
	modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

[rtl/core/linear_resampler_to_16k.sv]
`timescale 1ns / 1ps
// linear_resampler_to_16k: top level, rate register and front/queue/back/datapath
// depends on lrs_pkg, lrs_in_if, lrs_out_if, lrs_front, lrs_queue, lrs_back, lrs_interp
//
//   channel   kind          beat payload
//   pcm       stream sink   sample_in (s16), last_in
//   pcm16k    stream source sample_out (s16 Q15), last_out
//   cfg       write only    cfg_wr_data = source_rate (u18), taken when cfg_wr_en
//
// one input beat per cycle is taken while the job queue has room
// the back-end sequencer issues one output at a time, or retires an input that yields
// none, and holds while pcm16k stalls; a mid-clip input whose outputs exceed the
// per-input limit then catches up its phase in the serial remainder unit
// a sample is registered in the job queue and then in each datapath stage before it leaves
// arst_n clears clip state, queue and pipeline, and sets the rate to TARGET_RATE
// a stall on pcm16k freezes the datapath and sequencer; the queue keeps pcm going until full

module linear_resampler_to_16k #(
	parameter int TARGET_RATE    = lrs_pkg::TARGET_RATE_DEF,
	parameter int MAX_OUT_PER_IN = lrs_pkg::MAX_OUT_DEF,
	parameter int QUEUE_DEPTH    = lrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lrs_pkg::RATE_W-1:0]  cfg_wr_data,
	lrs_in_if.sink                      pcm,
	lrs_out_if.source                   pcm16k
);

	logic [lrs_pkg::RATE_W-1:0]  source_rate_q;
	logic                        q_full;
	logic                        push;
	lrs_pkg::job_t               push_job;
	logic                        pop;
	logic                        head_valid;
	lrs_pkg::job_t               head_job;
	logic                        iss_valid;
	lrs_pkg::issue_t             iss;
	logic                        iss_ready;

	// source rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rate_q <= lrs_pkg::RATE_W'(TARGET_RATE);
		end else if (cfg_wr_en) begin
			source_rate_q <= cfg_wr_data;
		end
	end

	lrs_front #(
		.TARGET_RATE (TARGET_RATE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pcm         (pcm),
		.source_rate (source_rate_q),
		.q_full      (q_full),
		.push        (push),
		.job         (push_job)
	);

	lrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lrs_back #(
		.TARGET_RATE    (TARGET_RATE),
		.MAX_OUT_PER_IN (MAX_OUT_PER_IN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.source_rate (source_rate_q),
		.head_valid  (head_valid),
		.head        (head_job),
		.pop         (pop),
		.iss_valid   (iss_valid),
		.iss         (iss),
		.iss_ready   (iss_ready)
	);

	lrs_interp #(
		.TARGET_RATE (TARGET_RATE)
	) u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.iss_valid (iss_valid),
		.iss       (iss),
		.iss_ready (iss_ready),
		.res       (pcm16k)
	);

endmodule

[rtl/core/lrs_front.sv]
`timescale 1ns / 1ps
// lrs_front: accepts input beats, tracks the previous sample and classifies jobs
// depends on lrs_pkg and lrs_in_if

module lrs_front #(
	parameter int TARGET_RATE = lrs_pkg::TARGET_RATE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lrs_in_if.sink                       pcm,
	input  logic [lrs_pkg::RATE_W-1:0]   source_rate,
	input  logic                         q_full,
	output logic                         push,
	output lrs_pkg::job_t                job
);

	localparam logic [lrs_pkg::RATE_W-1:0] T_R = lrs_pkg::RATE_W'(TARGET_RATE);

	logic                                 have_q;
	logic signed [lrs_pkg::SAMPLE_W-1:0]  prev_q;
	logic                                 accept;
	logic                                 is_pass;

	// take a beat whenever the queue has room
	assign pcm.ready = !q_full;
	assign accept    = pcm.valid && pcm.ready;
	assign is_pass   = (source_rate == '0) || (source_rate == T_R);

	// classify the beat
	always_comb begin
		job.last = pcm.last_in;
		job.prev = prev_q;
		job.cur  = pcm.sample_in;
		priority if (is_pass) begin
			job.kind = lrs_pkg::JOB_PASS;
		end else if (!have_q) begin
			job.kind = lrs_pkg::JOB_FIRST_LAST;
		end else if (pcm.last_in) begin
			job.kind = lrs_pkg::JOB_LAST;
		end else begin
			job.kind = lrs_pkg::JOB_MID;
		end
	end

	// outside passthrough, the opening sample of a clip that is not also its last only gets stored
	assign push = accept && (is_pass || have_q || pcm.last_in);

	// clip state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			prev_q <= '0;
		end else if (accept) begin
			if (pcm.last_in) begin
				have_q <= 1'b0;
				prev_q <= '0;
			end else begin
				have_q <= 1'b1;
				prev_q <= pcm.sample_in;
			end
		end
	end

endmodule

[rtl/core/lrs_queue.sv]
`timescale 1ns / 1ps
// lrs_queue: small first-word-fall-through job queue between front and back end
// depends on lrs_pkg

module lrs_queue #(
	parameter int DEPTH = lrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lrs_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output lrs_pkg::job_t  head_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	lrs_pkg::job_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + AW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	// the back end only retires a job that is present
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !pop)
		else $error("job popped from empty queue");

endmodule

[rtl/core/lrs_back.sv]
`timescale 1ns / 1ps
// lrs_back: per-job sequencer, steps the phase and issues interpolation requests
// depends on lrs_pkg

module lrs_back #(
	parameter int TARGET_RATE    = lrs_pkg::TARGET_RATE_DEF,
	parameter int MAX_OUT_PER_IN = lrs_pkg::MAX_OUT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lrs_pkg::RATE_W-1:0]  source_rate,
	input  logic                        head_valid,
	input  lrs_pkg::job_t               head,
	output logic                        pop,
	output logic                        iss_valid,
	output lrs_pkg::issue_t             iss,
	input  logic                        iss_ready
);

	localparam int RW = lrs_pkg::RATE_W;
	localparam int PW = RW + 2;
	localparam int NW = $clog2(MAX_OUT_PER_IN + 1);
	localparam int DW = $clog2(TARGET_RATE + 1);
	localparam int CW = (DW > 1) ? $clog2(DW) : 1;
	localparam logic [PW-1:0] T_P      = PW'(TARGET_RATE);
	localparam logic [PW-1:0] T2_P     = PW'(2 * TARGET_RATE);
	localparam logic [NW-1:0] MAX_N    = NW'(MAX_OUT_PER_IN);
	localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

	lrs_pkg::back_state_t  state_q;
	lrs_pkg::back_state_t  state_d;
	logic [RW-1:0]         p_q;
	logic [NW-1:0]         n_q;
	logic [RW-1:0]         rem_q;
	logic [DW-1:0]         dsr_q;
	logic [CW-1:0]         cnt_q;

	logic [PW-1:0]  r_p;
	logic [PW-1:0]  p_cur;
	logic [PW-1:0]  p1;
	logic [PW-1:0]  p2;
	logic [PW-1:0]  pn;
	logic [PW-1:0]  pnr;
	logic [NW-1:0]  nn;
	logic           emit;
	logic           done;
	logic           direct;
	logic           run;
	logic           fire;
	logic           to_div;
	logic [RW:0]    remsh;
	logic [RW:0]    rem_sub;
	logic [RW-1:0]  rem_nx;
	logic [RW-1:0]  skip_phase;
	logic           div_end;

	// loop condition of one job kind at phase x, with xr = x + rate
	function automatic logic more(lrs_pkg::job_kind_t k, logic [PW-1:0] x,
		logic [PW-1:0] xr, logic [NW-1:0] cnt);
		logic ok;
		unique case (k)
			lrs_pkg::JOB_PASS:       ok = (cnt == '0);
			lrs_pkg::JOB_FIRST_LAST: ok = (xr <= T_P);
			lrs_pkg::JOB_MID:        ok = (x < T_P);
			lrs_pkg::JOB_LAST:       ok = (xr <= T2_P);
			default:                 ok = 1'b0;
		endcase
		return (cnt < MAX_N) && ok;
	endfunction

	// one step of the head job, with look-ahead to spot its final output
	always_comb begin
		r_p    = PW'(source_rate);
		p_cur  = PW'(p_q);
		p1     = p_cur + r_p;
		p2     = p_cur + {r_p[PW-2:0], 1'b0};
		emit   = more(head.kind, p_cur, p1, n_q);
		pn     = emit ? p1 : p_cur;
		pnr    = emit ? p2 : p1;
		nn     = n_q + NW'(emit);
		done   = !more(head.kind, pn, pnr, nn);
		direct = (head.kind == lrs_pkg::JOB_PASS) || (head.kind == lrs_pkg::JOB_FIRST_LAST)
			|| ((head.kind == lrs_pkg::JOB_LAST) && (p_cur >= T_P));
		run    = (state_q == lrs_pkg::BK_RUN) && head_valid;
		fire   = run && (!emit || iss_ready);
		to_div = fire && done && (head.kind == lrs_pkg::JOB_MID) && (pn < T_P);
	end

	// restoring remainder unit for phase catch-up after dropped outputs
	always_comb begin
		remsh      = {rem_q, dsr_q[DW-1]};
		rem_sub    = remsh - {1'b0, source_rate};
		rem_nx     = (remsh >= {1'b0, source_rate}) ? rem_sub[RW-1:0] : remsh[RW-1:0];
		skip_phase = (rem_nx == '0) ? '0 : source_rate - rem_nx;
		div_end    = (state_q == lrs_pkg::BK_DIV) && (cnt_q == CNT_LAST);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrs_pkg::BK_RUN: if (to_div) begin
				state_d = lrs_pkg::BK_DIV;
			end
			lrs_pkg::BK_DIV: if (div_end) begin
				state_d = lrs_pkg::BK_RUN;
			end
			default: state_d = lrs_pkg::BK_RUN;
		endcase
	end

	// outputs
	always_comb begin
		iss_valid = run && emit;
		pop       = fire && done;
		iss.a     = direct ? head.cur : head.prev;
		iss.b     = head.cur;
		iss.p     = direct ? '0 : p_q;
		iss.last  = (head.kind == lrs_pkg::JOB_PASS) ? head.last
			: ((head.kind != lrs_pkg::JOB_MID) && done);
	end

	// sequencer state, phase and output count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrs_pkg::BK_RUN;
			p_q     <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				if (done) begin
					n_q <= '0;
					if ((head.kind == lrs_pkg::JOB_MID) && (pn >= T_P)) begin
						p_q <= RW'(pn - T_P);
					end else begin
						p_q <= '0;
					end
				end else begin
					p_q <= pn[RW-1:0];
					n_q <= nn;
				end
			end else if (div_end) begin
				p_q <= skip_phase;
			end
			if (to_div) begin
				cnt_q <= '0;
			end else if (state_q == lrs_pkg::BK_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// remainder datapath
	always_ff @(posedge clk) begin
		if (to_div) begin
			dsr_q <= DW'(T_P - pn);
			rem_q <= '0;
		end else if (state_q == lrs_pkg::BK_DIV) begin
			dsr_q <= {dsr_q[DW-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q < MAX_N)
		else $error("output count of a job reached its limit without retiring");

	a_clip_end_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && done && (head.kind != lrs_pkg::JOB_MID)) |=> (p_q == '0))
		else $error("phase not cleared at end of clip");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == lrs_pkg::BK_DIV) |-> ##(DW) (state_q == lrs_pkg::BK_RUN))
		else $error("phase catch-up took the wrong number of cycles");

endmodule

[rtl/core/lrs_interp.sv]
`timescale 1ns / 1ps
// lrs_interp: four-stage interpolation datapath with rounding divide by the target rate
// depends on lrs_pkg and lrs_out_if

module lrs_interp #(
	parameter int TARGET_RATE = lrs_pkg::TARGET_RATE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             iss_valid,
	input  lrs_pkg::issue_t  iss,
	output logic             iss_ready,
	lrs_out_if.source        res
);

	localparam int SW   = lrs_pkg::SAMPLE_W;
	localparam int TW   = $clog2(TARGET_RATE + 1);
	localparam int NUMW = TW + 18;
	localparam int XW   = TW + 16;
	localparam int SH   = XW;
	localparam int MW   = SH - TW + 2;
	localparam int QW   = SW + 1;
	localparam int PAW  = lrs_pkg::RATE_W + SW + 2;
	localparam logic signed [TW:0] T_S    = (TW + 1)'(TARGET_RATE);
	localparam logic [TW-1:0]      T_U    = TW'(TARGET_RATE);
	localparam logic [XW-1:0]      T_X    = XW'(TARGET_RATE);
	localparam logic [XW-1:0]      T2_X   = XW'(2 * TARGET_RATE);
	localparam logic [XW-1:0]      HALF_T = XW'(TARGET_RATE / 2);
	localparam logic [MW-1:0]      RECIP  = MW'((64'd1 << SH) / TARGET_RATE);

	logic                     en;
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     valid_s3;
	logic                     valid_s4;
	logic signed [NUMW-1:0]   pp_s1;
	logic signed [NUMW-1:0]   ta_s1;
	logic                     last_s1;
	logic [XW-1:0]            x_s2;
	logic                     neg_s2;
	logic                     last_s2;
	logic [XW-1:0]            x_s3;
	logic [QW-1:0]            q0_s3;
	logic                     neg_s3;
	logic                     last_s3;
	logic signed [SW-1:0]     sample_s4;
	logic                     last_s4;

	logic signed [SW:0]       diff;
	logic signed [PAW-1:0]    pp_c;
	logic signed [SW+TW:0]    ta_c;
	logic signed [NUMW-1:0]   num_c;
	logic [NUMW-1:0]          mag_c;
	logic [XW+MW-1:0]         prod_c;
	logic [QW+TW-1:0]         qt_c;
	logic [XW-1:0]            rem_c;
	logic [QW-1:0]            q_c;
	logic [QW-1:0]            res_c;

	// whole pipe moves when the output register is free
	assign en        = !valid_s4 || res.ready;
	assign iss_ready = en;

	// stage 1: p*(b-a) and T*a
	always_comb begin
		diff = {iss.b[SW-1], iss.b} - {iss.a[SW-1], iss.a};
		pp_c = $signed({1'b0, iss.p}) * diff;
		ta_c = iss.a * T_S;
	end

	// stage 2: numerator, magnitude and rounding offset
	always_comb begin
		num_c = pp_s1 + ta_s1;
		mag_c = num_c[NUMW-1] ? NUMW'(-num_c) : NUMW'(num_c);
	end

	// stage 3: quotient estimate by reciprocal
	assign prod_c = x_s2 * RECIP;

	// stage 4: one-step correction and sign
	always_comb begin
		qt_c  = q0_s3 * T_U;
		rem_c = x_s3 - XW'(qt_c);
		q_c   = q0_s3 + QW'(rem_c >= T_X);
		res_c = neg_s3 ? QW'(-q_c) : q_c;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= iss_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1     <= NUMW'(pp_c);
			ta_s1     <= NUMW'(ta_c);
			last_s1   <= iss.last;
			x_s2      <= XW'(mag_c) + HALF_T;
			neg_s2    <= num_c[NUMW-1];
			last_s2   <= last_s1;
			x_s3      <= x_s2;
			q0_s3     <= prod_c[SH +: QW];
			neg_s3    <= neg_s2;
			last_s3   <= last_s2;
			sample_s4 <= $signed(res_c[SW-1:0]);
			last_s4   <= last_s3;
		end
	end

	assign res.valid      = valid_s4;
	assign res.sample_out = sample_s4;
	assign res.last_out   = last_s4;

	// reciprocal estimate is never more than one below the true quotient
	a_recip_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rem_c < T2_X))
		else $error("reciprocal quotient estimate off by more than one");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for linear_resampler_to_16k, predicts 16 kHz output beats
// depends on lrs_pkg, lrs_in_if, lrs_out_if and the resampler rtl

// one expected or observed output beat
typedef struct packed {
	logic signed [lrs_pkg::SAMPLE_W-1:0]  sample;
	logic                                 last;
} pcm16k_beat_t;

// predicts output beats per accepted pcm beat and checks the observed stream
class resample_scoreboard;
	localparam longint TR       = lrs_pkg::TARGET_RATE_DEF;
	localparam int     OUT_CAP  = lrs_pkg::MAX_OUT_DEF;
	localparam int     PRINT_CAP = 40;

	logic [lrs_pkg::RATE_W-1:0]           rate;
	logic signed [lrs_pkg::SAMPLE_W-1:0]  held_sample;
	bit                                   held_valid;
	logic [lrs_pkg::RATE_W-1:0]           phase;
	pcm16k_beat_t                         expected_q[$];
	int                                   predicted;
	int                                   errors;

	function new();
		rate = lrs_pkg::RATE_W'(TR);
		held_sample = '0;
		held_valid = 1'b0;
		phase = '0;
		predicted = 0;
		errors = 0;
	endfunction

	task report(input string msg);
		if (errors < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	function void set_rate(input logic [lrs_pkg::RATE_W-1:0] value);
		rate = value;
	endfunction

	function void expect_beat(input logic signed [lrs_pkg::SAMPLE_W-1:0] s, input logic l);
		pcm16k_beat_t b;
		b.sample = s;
		b.last = l;
		expected_q.push_back(b);
		predicted++;
	endfunction

	// weighted blend of two samples at phase p/TR, rounded half away from zero
	function logic signed [lrs_pkg::SAMPLE_W-1:0] blend(
		input logic signed [lrs_pkg::SAMPLE_W-1:0] a,
		input logic signed [lrs_pkg::SAMPLE_W-1:0] b,
		input longint p);
		longint num;
		longint mag;
		longint q;
		logic signed [lrs_pkg::SAMPLE_W-1:0] res;
		num = (TR - p) * longint'(a) + p * longint'(b);
		mag = (num < 0) ? -num : num;
		q = (mag + TR / 2) / TR;
		res = lrs_pkg::SAMPLE_W'((num < 0) ? -q : q);
		return res;
	endfunction

	// accepted pcm beat: work out every output beat it causes
	function void take_sample(input logic signed [lrs_pkg::SAMPLE_W-1:0] s, input logic l);
		longint r;
		longint p;
		int n;
		r = longint'(rate);
		p = longint'(phase);
		n = 0;

		// passthrough rates
		if (r == 0 || r == TR) begin
			expect_beat(s, l);
			held_sample = l ? '0 : s;
			held_valid = !l;
			phase = '0;
			return;
		end

		if (!held_valid) begin
			// first sample of a clip only primes the history
			if (!l) begin
				held_sample = s;
				held_valid = 1'b1;
				phase = '0;
				return;
			end
			// single-sample clip repeats the sample
			p = 0;
			while (n < OUT_CAP && p + r <= TR) begin
				expect_beat(s, 1'b0);
				n++;
				p += r;
			end
		end else if (l) begin
			// closing sample, positions past it reuse it
			while (n < OUT_CAP && p + r <= 2 * TR) begin
				expect_beat((p < TR) ? blend(held_sample, s, p) : s, 1'b0);
				n++;
				p += r;
			end
		end else begin
			// mid clip, outputs past the cap are skipped but the phase moves on
			while (n < OUT_CAP && p < TR) begin
				expect_beat(blend(held_sample, s, p), 1'b0);
				n++;
				p += r;
			end
			if (p < TR)
				p += r * ((TR - p + r - 1) / r);
			p -= TR;
			held_sample = s;
			phase = lrs_pkg::RATE_W'(p);
			return;
		end

		// end of clip marks the final beat and clears clip state
		if (n > 0)
			expected_q[expected_q.size() - 1].last = 1'b1;
		held_sample = '0;
		held_valid = 1'b0;
		phase = '0;
	endfunction

	task check_output(input logic signed [lrs_pkg::SAMPLE_W-1:0] s, input logic l);
		pcm16k_beat_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected beat sample=%0d last=%0b", s, l));
			return;
		end
		want = expected_q.pop_front();
		if (s !== want.sample)
			report($sformatf("sample_out %0d, predicted %0d", s, want.sample));
		if (l !== want.last)
			report($sformatf("last_out %0b, predicted %0b", l, want.last));
	endtask
endclass

module tb_top;

	localparam int QUIET_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int NUM_PHASES      = 11;
	localparam int ITEMS_PER_PHASE = 24;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [lrs_pkg::RATE_W-1:0]  cfg_wr_data;
	idle_mode_t                  idle_mode;
	logic                        hold_off;
	int                          quiet_count;
	resample_scoreboard          sb;

	lrs_in_if  pcm_ch();
	lrs_out_if pcm16k_ch();

	linear_resampler_to_16k uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pcm         (pcm_ch),
		.pcm16k      (pcm16k_ch)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver: random stalls by idle mode, long hold-off on request
	always @(posedge clk) begin
		if (hold_off)
			pcm16k_ch.ready <= 1'b0;
		else begin
			case (idle_mode)
				IDLE_RECV: pcm16k_ch.ready <= ($urandom_range(0, 99) >= 83);
				IDLE_BOTH: pcm16k_ch.ready <= ($urandom_range(0, 99) >= 33);
				default:   pcm16k_ch.ready <= 1'b1;
			endcase
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && pcm16k_ch.valid && pcm16k_ch.ready)
			sb.check_output(pcm16k_ch.sample_out, pcm16k_ch.last_out);
	end

	// watchdog on cycles with no beat moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (pcm_ch.valid && pcm_ch.ready) || (pcm16k_ch.valid && pcm16k_ch.ready)
				|| cfg_wr_en)
			quiet_count <= 0;
		else if (quiet_count >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_count);
			$display("FAIL linear_resampler_to_16k");
			$finish;
		end else
			quiet_count <= quiet_count + 1;
	end

	// offer one pcm beat, with random gaps, and wait for it to be taken
	task automatic send_sample(input logic signed [lrs_pkg::SAMPLE_W-1:0] s, input logic l);
		int pct;
		case (idle_mode)
			IDLE_SEND: pct = 83;
			IDLE_BOTH: pct = 33;
			default:   pct = 0;
		endcase
		while ($urandom_range(0, 99) < pct) begin
			pcm_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pcm_ch.valid <= 1'b1;
		pcm_ch.sample_in <= s;
		pcm_ch.last_in <= l;
		do
			@(posedge clk);
		while (!pcm_ch.ready);
		sb.take_sample(s, l);
	endtask

	// stop sending, wait for all predicted beats, then let the pipeline go quiet
	task automatic settle();
		pcm_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [lrs_pkg::RATE_W-1:0] value);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.set_rate(value);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [lrs_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return '0;
			default: return lrs_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [lrs_pkg::RATE_W-1:0] rate_val;
		int items;
		int len;

		sb = new();
		idle_mode = IDLE_NONE;
		hold_off <= 1'b0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		pcm_ch.valid <= 1'b0;
		pcm_ch.sample_in <= '0;
		pcm_ch.last_in <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// passthrough at the reset rate, sample extremes
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b1);
		// rate zero is passthrough too
		write_rate('0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd1, 1'b1);
		// 2x upsampling: single-sample clip, then a tie in rounding
		write_rate(lrs_pkg::RATE_W'(8000));
		send_sample(16'sd12345, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		// slowest rate overflows the per-input limit
		write_rate(lrs_pkg::RATE_W'(1));
		send_sample(16'sd100, 1'b0);
		send_sample(-16'sd100, 1'b1);
		// clips too short to yield any output
		write_rate(lrs_pkg::RATE_W'(48000));
		send_sample(16'sd500, 1'b0);
		send_sample(-16'sd500, 1'b1);
		write_rate(lrs_pkg::RATE_W'(192000));
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		// rate changed in the middle of a clip
		write_rate(lrs_pkg::RATE_W'(11025));
		send_sample(16'sd1000, 1'b0);
		send_sample(-16'sd2000, 1'b0);
		send_sample(16'sd3000, 1'b0);
		write_rate(lrs_pkg::RATE_W'(44100));
		send_sample(-16'sd4000, 1'b0);
		send_sample(16'sd5000, 1'b1);

		// random clips over a sweep of rates and idle modes
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       rate_val = '0;
				1:       rate_val = lrs_pkg::RATE_W'(192000);
				2:       rate_val = lrs_pkg::RATE_W'(1);
				3:       rate_val = lrs_pkg::RATE_W'(16000);
				4:       rate_val = lrs_pkg::RATE_W'(8000);
				default: rate_val = ($urandom_range(0, 2) == 0) ?
					lrs_pkg::RATE_W'($urandom_range(1000, 16000)) :
					lrs_pkg::RATE_W'($urandom_range(1, 192000));
			endcase
			write_rate(rate_val);
			idle_mode = idle_mode_t'(ph % 4);
			// long receiver hold-off while the sender keeps offering
			if (ph == 4)
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_OFF_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			items = 0;
			while (items < ITEMS_PER_PHASE) begin
				if (rate_val >= 96000)
					len = $urandom_range(8, 40);
				else if (rate_val != 0 && rate_val < 2000)
					len = $urandom_range(1, 4);
				else
					len = $urandom_range(1, 12);
				for (int k = 0; k < len; k++)
					send_sample(pick_sample(), k == len - 1);
				items += len;
			end
		end

		idle_mode = IDLE_NONE;
		settle();
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d predicted beats never arrived", sb.expected_q.size()));
		if (sb.errors == 0)
			$display("PASS linear_resampler_to_16k");
		else
			$display("FAIL linear_resampler_to_16k");
		$finish;
	end

endmodule
